[rtl/core/lod_pkg.sv]
// Shared types and constants for the level-of-detail select and blend block.
`default_nettype none
package lod_pkg;
    localparam int ENTITIES = 64;
    localparam int SLOT_W = 6;
    localparam int unsigned Q_ONE = 32768;
    localparam logic [15:0] PROG_ONE = 16'd32768;

    typedef enum logic [2:0] {
        REG_LEVEL_COUNT = 3'd0,
        REG_DIST_LIMITS = 3'd1,
        REG_SIZE_LIMITS = 3'd2,
        REG_SEL_MODE    = 3'd3,
        REG_LOD_BIAS    = 3'd4,
        REG_MIN_SIZE    = 3'd5,
        REG_BLEND_EN    = 3'd6,
        REG_TRANS_TIME  = 3'd7
    } reg_idx_t;

    // classified query handed from front to back
    typedef struct packed {
        logic              culled;
        logic              size_mode;
        logic [1:0]        level;      // distance-mode level
        logic [2:0]        n;
        logic [15:0]       size;
        logic [19:0]       elapsed;
        logic [SLOT_W-1:0] slot;
    } query_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_DIV1, BK_SEL, BK_READ, BK_DIV2, BK_WRITE, BK_OUT
    } bk_state_t;
endpackage
`default_nettype wire

[rtl/core/lod_div.sv]
// Radix-2 restoring divider: 36-bit dividend by 20-bit divisor, one bit a cycle.
`default_nettype none
module lod_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [35:0] dividend,
    input  wire logic [19:0] divisor,
    output logic             done,
    output logic [35:0]      quotient
);
    import lod_pkg::*;
    logic [35:0] q_reg, q_next;
    logic [20:0] r_reg, r_next;
    logic [19:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [20:0] sh;
    logic [21:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done = 1'b0;
        sh = {r_reg[19:0], q_reg[35]};
        diff = {1'b0, sh} - {2'b0, d_reg};
        if (start) begin
            q_next = dividend; r_next = '0; d_next = divisor;
            cnt_next = 6'd36; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[21]) begin
                r_next = diff[20:0];
                q_next = {q_reg[34:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[34:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end
    assign quotient = q_reg;
endmodule
`default_nettype wire

[rtl/core/lod_front.sv]
// Front end: accept a query, bias the distance, pick a distance-mode level.
`default_nettype none
module lod_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [5:0]    s_entity_slot,
    input  wire logic [15:0]   s_distance,
    input  wire logic [15:0]   s_screen_size,
    input  wire logic [19:0]   s_elapsed,
    input  wire logic [2:0]    num_levels,
    input  wire logic [63:0]   distance_limits,
    input  wire logic          selection_mode,
    input  wire logic [11:0]   lod_bias,
    output lod_pkg::query_t    q_data,
    output logic               q_valid,
    input  wire logic          q_ready
);
    import lod_pkg::*;
    // stage 1: multiply; stage 2: compare
    logic        v1_reg, v1_next;
    logic [27:0] prod_reg;
    query_t      p1_reg;
    logic        v2_reg;
    query_t      p2_reg, p2_next;
    logic [15:0] b;
    logic [2:0]  n;
    logic [1:0]  lvl;
    logic        found;
    logic        adv2;

    assign adv2 = !v2_reg || q_ready;
    assign s_ready = !v1_reg || adv2;
    assign n = (num_levels > 3'd4) ? 3'd4 : num_levels;

    always_comb begin
        v1_next = v1_reg;
        if (s_ready) v1_next = s_valid;
        else if (adv2) v1_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            if (adv2) v2_reg <= v1_reg;
        end
        if (s_ready && s_valid) begin
            prod_reg <= s_distance * lod_bias;
            p1_reg.culled    <= (n == 3'd0);
            p1_reg.size_mode <= selection_mode;
            p1_reg.level     <= 2'd0;
            p1_reg.n         <= n;
            p1_reg.size      <= s_screen_size;
            p1_reg.elapsed   <= s_elapsed;
            p1_reg.slot      <= s_entity_slot;
        end
        if (adv2 && v1_reg) p2_reg <= p2_next;
    end

    always_comb begin
        b = (prod_reg[27:24] != 4'd0) ? 16'hFFFF : prod_reg[23:8];
        found = 1'b0;
        lvl = 2'(p1_reg.n - 3'd1);
        for (int i = 3; i >= 0; i--) begin
            if (3'(i) < p1_reg.n && b <= distance_limits[16*i +: 16]) begin
                lvl = 2'(i);
                found = 1'b1;
            end
        end
        p2_next = p1_reg;
        p2_next.level = lvl;
    end

    assign q_valid = v2_reg;
    assign q_data = p2_reg;
endmodule
`default_nettype wire

[rtl/core/lod_back.sv]
// Back end: size division, per-entity state update and blend progress.
`default_nettype none
module lod_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  lod_pkg::query_t    q_data,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic [63:0]   size_limits,
    input  wire logic [11:0]   lod_bias,
    input  wire logic [15:0]   min_size,
    input  wire logic          blend_enable,
    input  wire logic [19:0]   blend_time,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_culled,
    output logic [1:0]         m_level,
    output logic [15:0]        m_blend
);
    import lod_pkg::*;
    bk_state_t   st_reg, st_next;
    query_t      qr_reg;
    logic [1:0]  tgt_reg;
    logic        cul_reg;
    logic [15:0] fac_reg;
    logic [1:0]  cur_rd_reg;
    logic        ok_rd_reg;
    // the previous level feeds no output, so only current level and progress are kept
    logic [1:0]  cur_mem [ENTITIES];
    logic [15:0] prog_mem [ENTITIES];
    logic [ENTITIES-1:0] ok_reg;   // entry written since reset
    logic [15:0] prog_rd_reg;
    logic        mv_reg;
    logic        m_cul_reg;
    logic [1:0]  m_lvl_reg;
    logic [15:0] m_fac_reg;
    logic        dstart;
    logic [35:0] dnd;
    logic [19:0] dsr;
    logic        ddone;
    logic [35:0] quo;
    logic [15:0] bsz;
    logic [1:0]  slvl;
    logic [SLOT_W-1:0] sl;
    logic [1:0]  cur;
    logic [15:0] prog_cur;
    logic        change;
    logic [36:0] psum;
    logic [15:0] pnew;

    lod_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .dividend(dnd),
        .divisor(dsr), .done(ddone), .quotient(quo)
    );

    assign sl = qr_reg.slot;
    assign q_ready = (st_reg == BK_IDLE);
    assign bsz = (lod_bias == 12'd0 || quo[35:16] != 20'd0) ? 16'hFFFF : quo[15:0];
    assign cur = ok_rd_reg ? cur_rd_reg : 2'd0;
    assign prog_cur = ok_rd_reg ? prog_rd_reg : PROG_ONE;
    assign change = (cur != tgt_reg);
    assign psum = {21'd0, (change ? 16'd0 : prog_cur)} + {1'b0, quo};
    assign pnew = (blend_time == 20'd0 || psum > 37'(Q_ONE)) ? PROG_ONE
                                                              : psum[15:0];

    always_comb begin
        slvl = 2'(qr_reg.n - 3'd1);
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < qr_reg.n && bsz >= size_limits[16*i +: 16]) slvl = 2'(i);
        end
    end

    always_comb begin
        st_next = st_reg; dstart = 1'b0; dnd = '0; dsr = '0;
        unique case (st_reg)
            BK_IDLE: if (q_valid) begin
                if (q_data.culled) st_next = BK_OUT;
                else if (q_data.size_mode) begin
                    st_next = BK_DIV1; dstart = 1'b1;
                    dnd = {12'd0, q_data.size, 8'd0};
                    dsr = {8'd0, (lod_bias == 12'd0) ? 12'd1 : lod_bias};
                end else st_next = BK_READ;
            end
            BK_DIV1: if (ddone) st_next = BK_SEL;
            // drop to output without touching state when below the cull size
            BK_SEL: st_next = (bsz < min_size) ? BK_OUT : BK_READ;
            BK_READ: begin
                if (blend_enable) begin
                    st_next = BK_DIV2; dstart = 1'b1;
                    dnd = {1'b0, qr_reg.elapsed, 15'd0};
                    dsr = (blend_time == 20'd0) ? 20'd1 : blend_time;
                end else st_next = BK_WRITE;
            end
            BK_DIV2: if (ddone) st_next = BK_WRITE;
            BK_WRITE: st_next = BK_OUT;
            BK_OUT: if (!mv_reg || m_ready) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BK_IDLE;
            ok_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == BK_OUT && (!mv_reg || m_ready)) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
            if (st_reg == BK_WRITE) ok_reg[sl] <= 1'b1;
        end
        case (st_reg)
            BK_IDLE: if (q_valid) begin
                qr_reg  <= q_data;
                tgt_reg <= q_data.level;
                cul_reg <= q_data.culled;
                fac_reg <= '0;
            end
            BK_SEL: begin
                tgt_reg <= slvl;
                if (bsz < min_size) cul_reg <= 1'b1;
            end
            BK_READ: begin
                cur_rd_reg  <= cur_mem[sl];
                prog_rd_reg <= prog_mem[sl];
                ok_rd_reg   <= ok_reg[sl];
            end
            BK_WRITE: begin
                if (blend_enable) begin
                    cur_mem[sl] <= tgt_reg;
                    if (change || prog_cur != PROG_ONE) begin
                        prog_mem[sl] <= pnew;
                        fac_reg <= pnew;
                    end else prog_mem[sl] <= prog_cur;
                end else begin
                    cur_mem[sl] <= tgt_reg;
                    if (!ok_rd_reg) prog_mem[sl] <= PROG_ONE;
                end
            end
            BK_OUT: if (!mv_reg || m_ready) begin
                m_cul_reg <= cul_reg;
                m_lvl_reg <= cul_reg ? 2'd0 : tgt_reg;
                m_fac_reg <= cul_reg ? 16'd0 : fac_reg;
            end
            default: ;
        endcase
    end

    assign m_valid = mv_reg;
    assign m_culled = m_cul_reg;
    assign m_level = m_lvl_reg;
    assign m_blend = m_fac_reg;
endmodule
`default_nettype wire

[rtl/core/lod_level_select_blend.sv]
// Top level of the level-of-detail select and blend block.
// Usage:
//   Queries enter on s_valid/s_ready with slot, distance, screen size and
//   elapsed time; one word leaves on m_valid/m_ready per query with the
//   culled flag, the chosen level and the blend progress, in query order.
//   A two-stage front end biases the distance and ranks it against the
//   distance limits; a two-entry handoff lets it run ahead of the back end.
//   The back end holds the per-entity level and progress table and one
//   radix-2 divider, 36 quotient bits, one per cycle. The back end finishes
//   each query, through to its output register, before it takes the next.
//   Reset clears the control and state registers and marks every table
//   entry unwritten, which reads as level 0 and progress 1.0; no clearing
//   pass is needed.
//   A stalled m_ready holds the result word; the back end then stops, the
//   front end and handoff fill with four words and s_ready drops.
//   The user must write registers over APB only while the block is idle;
//   the block itself does not enforce it.
`default_nettype none
module lod_level_select_blend (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [5:0]  s_entity_slot,
    input  wire logic [15:0] s_distance,
    input  wire logic [15:0] s_screen_size,
    input  wire logic [19:0] s_elapsed,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_culled,
    output logic [1:0]       m_level,
    output logic [15:0]      m_blend,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import lod_pkg::*;

    logic [2:0]  level_cnt_reg;
    logic [63:0] dist_lim_reg, size_lim_reg;
    logic        sel_mode_reg, blend_en_reg;
    logic [11:0] bias_reg;
    logic [15:0] min_size_reg;
    logic [19:0] ttime_reg;
    reg_idx_t    ridx;
    logic        wr;

    // hold the queue between front and back
    query_t qf_data, qb_data;
    logic   qf_valid, qf_ready, qb_valid, qb_ready;
    query_t fifo_reg [2];
    logic   wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign pready = 1'b1;
    assign ridx = reg_idx_t'(paddr[5:3]);
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_cnt_reg <= '0; dist_lim_reg <= '0; size_lim_reg <= '0;
            sel_mode_reg <= 1'b0; bias_reg <= 12'd256; min_size_reg <= 16'd256;
            blend_en_reg <= 1'b0; ttime_reg <= 20'd100000;
        end else if (wr) begin
            unique case (ridx)
                REG_LEVEL_COUNT: level_cnt_reg <= pwdata[2:0];
                REG_DIST_LIMITS: dist_lim_reg <= pwdata;
                REG_SIZE_LIMITS: size_lim_reg <= pwdata;
                REG_SEL_MODE:    sel_mode_reg <= pwdata[0];
                REG_LOD_BIAS:    bias_reg <= pwdata[11:0];
                REG_MIN_SIZE:    min_size_reg <= pwdata[15:0];
                REG_BLEND_EN:    blend_en_reg <= pwdata[0];
                REG_TRANS_TIME:  ttime_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_LEVEL_COUNT: prdata = {61'd0, level_cnt_reg};
            REG_DIST_LIMITS: prdata = dist_lim_reg;
            REG_SIZE_LIMITS: prdata = size_lim_reg;
            REG_SEL_MODE:    prdata = {63'd0, sel_mode_reg};
            REG_LOD_BIAS:    prdata = {52'd0, bias_reg};
            REG_MIN_SIZE:    prdata = {48'd0, min_size_reg};
            REG_BLEND_EN:    prdata = {63'd0, blend_en_reg};
            REG_TRANS_TIME:  prdata = {44'd0, ttime_reg};
            default:         prdata = '0;
        endcase
    end

    lod_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_entity_slot(s_entity_slot), .s_distance(s_distance),
        .s_screen_size(s_screen_size), .s_elapsed(s_elapsed),
        .num_levels(level_cnt_reg), .distance_limits(dist_lim_reg),
        .selection_mode(sel_mode_reg), .lod_bias(bias_reg),
        .q_data(qf_data), .q_valid(qf_valid), .q_ready(qf_ready)
    );

    assign qf_ready = (cnt_reg != 2'd2);
    assign qb_valid = (cnt_reg != 2'd0);
    assign qb_data = fifo_reg[rp_reg];

    // advance queue pointers on push and pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (qf_valid && qf_ready) wp_reg <= ~wp_reg;
            if (qb_valid && qb_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(qf_valid && qf_ready) - 2'(qb_valid && qb_ready);
        end
        if (qf_valid && qf_ready) fifo_reg[wp_reg] <= qf_data;
    end

    lod_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_data(qb_data), .q_valid(qb_valid),
        .q_ready(qb_ready), .size_limits(size_lim_reg), .lod_bias(bias_reg),
        .min_size(min_size_reg), .blend_enable(blend_en_reg),
        .blend_time(ttime_reg), .m_valid(m_valid), .m_ready(m_ready),
        .m_culled(m_culled), .m_level(m_level),
        .m_blend(m_blend)
    );
endmodule
`default_nettype wire

[sim/lod_level_select_blend_test.sv]
// Testbench for the level-of-detail select and blend block.
`default_nettype none
module lod_level_select_blend_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lod_pkg::*;

    // One result word: culled flag, chosen level, blend factor.
    typedef struct packed {
        logic        culled;
        logic [1:0]  level;
        logic [15:0] blend;
    } lod_word_t;

    // Predicts each query's result and checks the block's result words in order.
    class lod_scoreboard;
        logic [2:0]  lvl_count;
        logic [63:0] dist_limits, size_limits;
        logic        size_mode, blend_en;
        logic [11:0] bias;
        logic [15:0] min_size;
        logic [19:0] trans_time;
        logic [1:0]  cur_level [64];
        logic [1:0]  prev_level [64];
        logic [15:0] progress [64];
        lod_word_t   pending[$];
        int          mismatches;
        int          words_checked;
        int          culled_seen;
        int          blended_seen;

        function void reset_state();
            lvl_count = 0; dist_limits = 0; size_limits = 0; size_mode = 0;
            bias = 256; min_size = 256; blend_en = 0; trans_time = 100000;
            for (int i = 0; i < 64; i++) begin
                cur_level[i] = 0;
                prev_level[i] = 0;
                progress[i] = PROG_ONE;
            end
            mismatches = 0;
            words_checked = 0;
            culled_seen = 0;
            blended_seen = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] v);
            case (idx)
                REG_LEVEL_COUNT: lvl_count = v[2:0];
                REG_DIST_LIMITS: dist_limits = v;
                REG_SIZE_LIMITS: size_limits = v;
                REG_SEL_MODE:    size_mode = v[0];
                REG_LOD_BIAS:    bias = v[11:0];
                REG_MIN_SIZE:    min_size = v[15:0];
                REG_BLEND_EN:    blend_en = v[0];
                REG_TRANS_TIME:  trans_time = v[19:0];
                default: ;
            endcase
        endfunction

        // Select the level, advance the slot's progress, queue the result.
        function void note_query(logic [5:0] slot, logic [15:0] dist_q,
                                 logic [15:0] size, logic [19:0] elapsed);
            lod_word_t   w;
            int unsigned n, target;
            logic [63:0] b, p;
            bit          found;
            w = '{culled: 1'b1, level: 2'd0, blend: 16'd0};
            n = (lvl_count > 4) ? 4 : lvl_count;
            target = 0;
            found = 0;
            if (n != 0) begin
                if (!size_mode) begin
                    b = (64'(dist_q) * 64'(bias)) >> 8;
                    if (b > 64'hFFFF) b = 64'hFFFF;
                    for (int i = 0; i < n; i++)
                        if (!found && b <= 64'(dist_limits[i*16 +: 16])) begin
                            target = i;
                            found = 1;
                        end
                end else begin
                    b = (bias == 0) ? 64'hFFFF : (64'(size) << 8) / 64'(bias);
                    if (b > 64'hFFFF) b = 64'hFFFF;
                    if (b < 64'(min_size)) begin
                        pending = {pending, w};
                        return;
                    end
                    for (int i = n; i > 0; i--)
                        if (!found && b >= 64'(size_limits[(i-1)*16 +: 16])) begin
                            target = i - 1;
                            found = 1;
                        end
                end
                if (!found) target = n - 1;
                w.culled = 0;
                w.level = target[1:0];
                if (blend_en) begin
                    if (cur_level[slot] != target[1:0]) begin
                        prev_level[slot] = cur_level[slot];
                        cur_level[slot] = target[1:0];
                        progress[slot] = 0;
                    end
                    if (progress[slot] < PROG_ONE) begin
                        p = 64'(progress[slot]);
                        if (trans_time == 0) p = 64'd32768;
                        else p += (64'(elapsed) << 15) / 64'(trans_time);
                        if (p > 64'd32768) p = 64'd32768;
                        progress[slot] = p[15:0];
                        w.blend = p[15:0];
                    end
                end else begin
                    cur_level[slot] = target[1:0];
                end
            end
            pending = {pending, w};
        endfunction

        function void check_word(lod_word_t got);
            lod_word_t exp_w;
            words_checked++;
            if (got.culled) culled_seen++;
            if (got.blend != 0) blended_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with nothing pending: %p", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.culled !== exp_w.culled || got.level !== exp_w.level ||
                got.blend !== exp_w.blend) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("ERROR: word %0d expected culled=%0b level=%0d blend=%0d, ",
                           words_checked, exp_w.culled, exp_w.level, exp_w.blend);
                    $display("got culled=%0b level=%0d blend=%0d",
                             got.culled, got.level, got.blend);
                end
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_valid, s_ready;
    logic [5:0]  s_entity_slot;
    logic [15:0] s_distance, s_screen_size;
    logic [19:0] s_elapsed;
    logic        m_valid, m_ready, m_culled;
    logic [1:0]  m_level;
    logic [15:0] m_blend;
    logic        psel, penable, pwrite, pready;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;

    lod_scoreboard lod_sb;
    int  cycle_count;
    int  queries_sent;
    bit  quiet_phase;      // no idling on either side
    bit  hold_off;         // receiver stalls for a long stretch

    localparam int CYCLE_LIMIT = 2_000_000;

    lod_level_select_blend u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_entity_slot, .s_distance,
        .s_screen_size, .s_elapsed, .m_valid, .m_ready, .m_culled, .m_level,
        .m_blend, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: idle at random unless in a quiet phase; drop ready during a hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                lod_sb.check_word('{culled: m_culled, level: m_level,
                                    blend: m_blend});
            m_ready <= !hold_off && (quiet_phase || $urandom_range(99) >= 9);
        end
    end

    // Write one register over APB: setup cycle, then access cycle.
    task automatic apb_write(reg_idx_t idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lod_sb.write_reg(idx, v);
    endtask

    // Offer one query and hold it until accepted; random idle before it.
    task automatic send_query(logic [5:0] slot, logic [15:0] dist_q,
                              logic [15:0] size, logic [19:0] elapsed);
        while (!quiet_phase && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_entity_slot <= slot;
        s_distance    <= dist_q;
        s_screen_size <= size;
        s_elapsed     <= elapsed;
        do @(posedge aclk); while (!s_ready);
        lod_sb.note_query(slot, dist_q, size, elapsed);
        queries_sent++;
    endtask

    // Release valid once the last query of a phase is in.
    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    // Wait for every pending word, then let the back end settle.
    task automatic drain();
        end_burst();
        while (lod_sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Four non-decreasing limits, from a base up by random steps, so levels vary.
    function automatic logic [63:0] ascending_limits(logic [15:0] base, int step);
        logic [63:0] v;
        int unsigned acc;
        acc = base;
        for (int i = 0; i < 4; i++) begin
            if (acc > 16'hFFFF) acc = 16'hFFFF;
            v[i*16 +: 16] = acc[15:0];
            acc += $urandom_range(step);
        end
        return v;
    endfunction

    task automatic random_config(int phase);
        apb_write(REG_LEVEL_COUNT, 64'($urandom_range(7)));
        apb_write(REG_DIST_LIMITS, ascending_limits(16'($urandom_range(4000)), 8000));
        apb_write(REG_SIZE_LIMITS, ascending_limits(16'($urandom_range(1000)), 3000));
        apb_write(REG_SEL_MODE, 64'(phase & 1));
        case (phase % 4)
            0: apb_write(REG_LOD_BIAS, 64'd1);
            1: apb_write(REG_LOD_BIAS, 64'hFFF);
            default: apb_write(REG_LOD_BIAS, 64'($urandom_range(4095)));
        endcase
        apb_write(REG_MIN_SIZE, (phase % 5 == 0) ? 64'hFFFF : 64'($urandom_range(600)));
        apb_write(REG_BLEND_EN, 64'((phase >> 1) & 1));
        case (phase % 3)
            0: apb_write(REG_TRANS_TIME, 64'd1);
            1: apb_write(REG_TRANS_TIME, 64'hFFFFF);
            default: apb_write(REG_TRANS_TIME, 64'($urandom_range(200000, 1)));
        endcase
    endtask

    // Random query aimed at the configured thresholds; small slot set for reuse.
    task automatic random_query();
        logic [5:0]  slot;
        logic [15:0] dist_q, size;
        logic [19:0] el;
        slot = ($urandom_range(99) < 80) ? 6'($urandom_range(7)) : 6'($urandom);
        dist_q = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16000));
        size = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5000));
        case ($urandom_range(3))
            0: el = 20'($urandom);
            1: el = 20'hFFFFF;
            default: el = 20'($urandom_range(20000));
        endcase
        send_query(slot, dist_q, size, el);
    endtask

    // Long receiver stall counted in cycles.
    initial begin
        hold_off = 0;
        wait (queries_sent >= 200);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        lod_sb = new();
        lod_sb.reset_state();
        cycle_count = 0;
        queries_sent = 0;
        quiet_phase = 0;
        aresetn = 0;
        s_valid = 0; s_entity_slot = 0; s_distance = 0; s_screen_size = 0; s_elapsed = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: level count zero culls everything.
        send_query(6'd0, 16'd0, 16'd0, 20'd0);
        send_query(6'd63, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        drain();

        // Distance mode, four levels, blending.
        apb_write(REG_LEVEL_COUNT, 64'd4);
        apb_write(REG_DIST_LIMITS, {16'd4000, 16'd3000, 16'd2000, 16'd1000});
        apb_write(REG_SIZE_LIMITS, {16'd4000, 16'd2000, 16'd1000, 16'd300});
        apb_write(REG_BLEND_EN, 64'd1);
        apb_write(REG_TRANS_TIME, 64'd1000);
        send_query(6'd1, 16'd0, 16'd0, 20'd0);         // level 0, no change
        send_query(6'd1, 16'd1500, 16'd0, 20'd0);      // change, zero progress
        send_query(6'd1, 16'd1500, 16'd0, 20'd400);    // partial blend
        send_query(6'd1, 16'd1500, 16'd0, 20'hFFFFF);  // clamp to one
        send_query(6'd1, 16'd1500, 16'd0, 20'd5);      // done: factor zero
        send_query(6'd2, 16'hFFFF, 16'd0, 20'd10);     // beyond all: last level
        send_query(6'd3, 16'd4000, 16'd0, 20'd10);     // exactly on a limit
        drain();

        // Level count above four saturates; zero bias gives zero distance.
        apb_write(REG_LEVEL_COUNT, 64'd7);
        apb_write(REG_LOD_BIAS, 64'd0);
        apb_write(REG_TRANS_TIME, 64'd0);
        send_query(6'd4, 16'hFFFF, 16'd0, 20'd1);
        drain();
        apb_write(REG_TRANS_TIME, 64'd100000);

        // Size mode: zero bias saturates, cull below minimum, fall back to last.
        apb_write(REG_SEL_MODE, 64'd1);
        send_query(6'd5, 16'd0, 16'd0, 20'd100);
        drain();
        apb_write(REG_LOD_BIAS, 64'd256);
        apb_write(REG_MIN_SIZE, 64'd256);
        send_query(6'd5, 16'd0, 16'd100, 20'd100);     // culled
        send_query(6'd5, 16'd0, 16'd256, 20'd100);     // at minimum, under all limits
        send_query(6'd5, 16'd0, 16'd1500, 20'd100);
        send_query(6'd5, 16'd0, 16'hFFFF, 20'd100);
        drain();
        apb_write(REG_LOD_BIAS, 64'd1);                // saturated quotient
        apb_write(REG_BLEND_EN, 64'd0);
        send_query(6'd6, 16'd0, 16'hFFFF, 20'd0);
        drain();

        // Random phases with fresh settings; one quiet phase without idling.
        for (int phase = 0; phase < 12; phase++) begin
            random_config(phase);
            quiet_phase = (phase == 3);
            repeat (50) random_query();
            drain();
        end
        quiet_phase = 0;

        $display("Sent %0d queries over 12 random settings; %0d result words checked,",
                 queries_sent, lod_sb.words_checked);
        $display("%0d culled, %0d with a nonzero blend factor.",
                 lod_sb.culled_seen, lod_sb.blended_seen);
        if (lod_sb.mismatches == 0 && lod_sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d words left pending",
                     lod_sb.mismatches, lod_sb.pending.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
